>>> rtl/sha1mh_pkg.sv
// SHA-1 message hasher package: item types, controller command and status
// structs, and the SHA-1 initial values and round constants.
// No dependencies.
package sha1mh_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_WORDS = 5;
  localparam int unsigned ROUNDS    = 80;

  localparam logic [5:0] POS_BLOCK_END = 6'd63;
  localparam logic [5:0] POS_LEN_START = 6'd56;

  localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
  localparam logic [2:0] LEN_LAST   = 3'd7;
  localparam logic [2:0] WORD_LAST  = 3'(NUM_WORDS - 1);

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] H_INIT0 = 32'h67452301;
  localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT3 = 32'h10325476;
  localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

  localparam logic [31:0] K_0_19  = 32'h5A827999;
  localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       last_byte;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_item_t;

  typedef enum logic [1:0] {
    BSEL_MSG,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      push;
    byte_sel_t byte_sel;
    logic [2:0] len_idx;
    logic      load_wv;
    logic      round_en;
    logic [6:0] round_idx;
    logic      add_chain;
    logic      restart;
    logic [2:0] out_idx;
  } sha1mh_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } sha1mh_status_t;

endpackage

>>> rtl/sha1mh_dp.sv
// SHA-1 datapath: 512-bit block window doubling as schedule shift line,
// working variables, chaining words and the message byte counter.
// Depends on sha1mh_pkg.
module sha1mh_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  sha1mh_pkg::sha1mh_cmd_t    cmd,
  input  logic [7:0]                 msg_byte,
  output sha1mh_pkg::sha1mh_status_t status,
  output sha1mh_pkg::dig_item_t      dig_item
);
  import sha1mh_pkg::*;

  logic [511:0] window;
  logic [5:0]   pos;
  logic [63:0]  byte_count;
  logic [31:0]  chain [NUM_WORDS];
  logic [31:0]  wa, wb, wc, wd, we;

  logic [63:0]  bit_len;
  logic [7:0]   push_byte;
  logic [31:0]  w0, w2, w8, w13, sched_x, sched_new;
  logic [31:0]  f, k, t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  assign bit_len = {byte_count[60:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      BSEL_MSG:  push_byte = msg_byte;
      BSEL_PAD:  push_byte = PAD_BYTE;
      BSEL_ZERO: push_byte = 8'h00;
      BSEL_LEN:  push_byte = bit_len[8'(63) - {2'b00, cmd.len_idx, 3'b000} -: 8];
      default:   push_byte = 8'h00;
    endcase
  end

  assign w0  = window[511 -: 32];
  assign w2  = window[447 -: 32];
  assign w8  = window[255 -: 32];
  assign w13 = window[95 -: 32];
  assign sched_x   = w13 ^ w8 ^ w2 ^ w0;
  assign sched_new = rotl(sched_x, 1);

  always_comb begin
    if (cmd.round_idx < 7'd20) begin
      f = (wb & wc) | (~wb & wd);
      k = K_0_19;
    end else if (cmd.round_idx < 7'd40) begin
      f = wb ^ wc ^ wd;
      k = K_20_39;
    end else if (cmd.round_idx < 7'd60) begin
      f = (wb & wc) | (wb & wd) | (wc & wd);
      k = K_40_59;
    end else begin
      f = wb ^ wc ^ wd;
      k = K_60_79;
    end
  end

  assign t = rotl(wa, 5) + f + we + k + w0;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      window <= {window[503:0], push_byte};
    end else if (cmd.round_en) begin
      window <= {window[479:0], sched_new};
    end
    if (cmd.load_wv) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
    end else if (cmd.round_en) begin
      wa <= t;
      wb <= wa;
      wc <= rotl(wb, 30);
      wd <= wc;
      we <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      pos        <= '0;
      byte_count <= '0;
      chain[0]   <= H_INIT0;
      chain[1]   <= H_INIT1;
      chain[2]   <= H_INIT2;
      chain[3]   <= H_INIT3;
      chain[4]   <= H_INIT4;
    end else begin
      if (cmd.push) begin
        pos <= pos + 6'd1;
        if (cmd.byte_sel == BSEL_MSG) begin
          byte_count <= byte_count + 64'd1;
        end
      end
      if (cmd.add_chain) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        chain[4] <= chain[4] + we;
      end
    end
  end

  assign status.pos = pos;

  always_comb begin
    case (cmd.out_idx)
      3'd0:    dig_item.digest_word = chain[0];
      3'd1:    dig_item.digest_word = chain[1];
      3'd2:    dig_item.digest_word = chain[2];
      3'd3:    dig_item.digest_word = chain[3];
      3'd4:    dig_item.digest_word = chain[4];
      default: dig_item.digest_word = chain[4];
    endcase
    dig_item.word_index = cmd.out_idx;
    dig_item.last_word  = (cmd.out_idx == WORD_LAST);
  end

endmodule

>>> rtl/sha1mh_ctrl.sv
// SHA-1 controller: byte intake, padding and length sequencing, round count
// and digest output handshake.
// Depends on sha1mh_pkg.
module sha1mh_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       msg_valid,
  output logic                       msg_stall,
  input  logic                       byte_present,
  input  logic                       last_byte,
  output logic                       dig_valid,
  input  logic                       dig_stall,
  input  sha1mh_pkg::sha1mh_status_t status,
  output sha1mh_pkg::sha1mh_cmd_t    cmd
);
  import sha1mh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FIN,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_t;

  state_t     state;
  logic [6:0] round;
  logic [2:0] lidx;
  logic [2:0] oidx;
  logic       pad_pend;
  logic       len_done;
  logic       first_done;

  logic       block_end;

  assign block_end = (status.pos == POS_BLOCK_END);
  assign msg_stall = (state != ST_IDLE);
  assign dig_valid = (state == ST_OUT);

  always_comb begin
    cmd = '0;
    cmd.byte_sel  = BSEL_MSG;
    cmd.len_idx   = lidx;
    cmd.round_idx = round;
    cmd.out_idx   = oidx;
    case (state)
      ST_IDLE: begin
        cmd.push = msg_valid && byte_present;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      ST_FIN: begin
        cmd.add_chain = 1'b1;
      end
      ST_PAD: begin
        if (!first_done) begin
          cmd.push     = 1'b1;
          cmd.byte_sel = BSEL_PAD;
        end else if (status.pos != POS_LEN_START) begin
          cmd.push     = 1'b1;
          cmd.byte_sel = BSEL_ZERO;
        end
      end
      ST_LEN: begin
        cmd.push     = 1'b1;
        cmd.byte_sel = BSEL_LEN;
      end
      ST_OUT: begin
        cmd.restart = !dig_stall && (oidx == WORD_LAST);
      end
      default: begin
        cmd = '0;
      end
    endcase
    cmd.load_wv = cmd.push && block_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      round      <= '0;
      lidx       <= '0;
      oidx       <= '0;
      pad_pend   <= 1'b0;
      len_done   <= 1'b0;
      first_done <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (msg_valid) begin
            first_done <= 1'b0;
            len_done   <= 1'b0;
            pad_pend   <= last_byte;
            if (byte_present && block_end) begin
              state <= ST_ROUND;
              round <= '0;
            end else if (last_byte) begin
              state <= ST_PAD;
            end
          end
        end
        ST_ROUND: begin
          round <= round + 7'd1;
          if (round == ROUND_LAST) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (len_done) begin
            state <= ST_OUT;
            oidx  <= '0;
          end else if (pad_pend) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PAD: begin
          if (!first_done) begin
            first_done <= 1'b1;
            if (block_end) begin
              state <= ST_ROUND;
              round <= '0;
            end
          end else if (status.pos == POS_LEN_START) begin
            state <= ST_LEN;
            lidx  <= '0;
          end else if (block_end) begin
            state <= ST_ROUND;
            round <= '0;
          end
        end
        ST_LEN: begin
          lidx <= lidx + 3'd1;
          if (lidx == LEN_LAST) begin
            state    <= ST_ROUND;
            round    <= '0;
            len_done <= 1'b1;
          end
        end
        ST_OUT: begin
          if (!dig_stall) begin
            if (oidx == WORD_LAST) begin
              state    <= ST_IDLE;
              oidx     <= '0;
              pad_pend <= 1'b0;
              len_done <= 1'b0;
            end else begin
              oidx <= oidx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/sha1_message_hasher.sv
// SHA-1 message hasher top level: controller and datapath.
// Depends on sha1mh_pkg, sha1mh_ctrl, sha1mh_dp.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   msg      | msg_valid/msg_stall  | msg_item: one message byte
//   dig      | dig_valid/dig_stall  | dig_item: one digest word
//
// A byte item is taken while idle; the byte that fills a 64-byte block adds
// the 80 rounds and an add into the chaining words.
// A last item adds padding (the pad byte, zero bytes up to the length field, an
// idle step before the length, the 8 length bytes, one or two compressions),
// then five digest items, one per cycle without stall.
// rst is synchronous; it loads the initial chaining words and clears the count.
// msg_stall is high whenever an item is in progress; dig_stall holds the word.
module sha1_message_hasher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  sha1mh_pkg::msg_item_t msg_item,
  output logic                  dig_valid,
  input  logic                  dig_stall,
  output sha1mh_pkg::dig_item_t dig_item
);
  import sha1mh_pkg::*;

  sha1mh_cmd_t    cmd;
  sha1mh_status_t status;

  sha1mh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .byte_present (msg_item.byte_present),
    .last_byte    (msg_item.last_byte),
    .dig_valid    (dig_valid),
    .dig_stall    (dig_stall),
    .status       (status),
    .cmd          (cmd)
  );

  sha1mh_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .msg_byte (msg_item.msg_byte),
    .status   (status),
    .dig_item (dig_item)
  );

endmodule
